### rtl/trc_pkg.sv
`timescale 1ns / 1ps

package trc_pkg;

	typedef enum logic [1:0] {
		FUNC_SAMPLE  = 2'd0,
		FUNC_TRIGGER = 2'd1,
		FUNC_READ    = 2'd2,
		FUNC_REARM   = 2'd3
	} func_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] sample_value;
		logic [7:0] read_offset;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       is_frozen;
		logic       is_armed;
		logic [7:0] write_position;
	} rsp_t;

	localparam logic [7:0] POST_TRIGGER_RESET = 8'd128;

endpackage

### rtl/trc_store.sv
`timescale 1ns / 1ps

module trc_store #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/triggered_ring_capture.sv
`timescale 1ns / 1ps

// Circular sample capture with a post-trigger stop point. Each request transaction
// (sample, trigger, read, rearm) yields one response transaction with the status after
// that request. A new request is taken every cycle unless rsp_stall backs up into req_stall;
// a response passes through the registered read port of the sample memory and the output
// register behind it. A sample taken while frozen leaves the buffer untouched. Read
// offset 0 returns the oldest entry; reads of never-written entries return undefined data.
module triggered_ring_capture #(
	parameter int BUFFER_DEPTH = 256,
	parameter int SAMPLE_BITS  = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  trc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output trc_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_data
);

	import trc_pkg::*;

	localparam int PW = $clog2(BUFFER_DEPTH);
	localparam logic [PW:0] DEPTH_W = (PW+1)'(BUFFER_DEPTH);
	localparam logic [PW-1:0] LAST_IDX = PW'(BUFFER_DEPTH - 1);
	localparam logic [PW-1:0] POST_RESET_MOD = PW'(int'(POST_TRIGGER_RESET) % BUFFER_DEPTH);

	logic [PW-1:0] mod_lut [256];

	for (genvar i = 0; i < 256; i++) begin : g_mod
		assign mod_lut[i] = PW'(i % BUFFER_DEPTH);
	end

	logic [PW-1:0] wp_q, stop_q, post_q;
	logic          armed_q, frozen_q;
	logic [PW-1:0] wp_n, stop_n, wp_inc, stop_calc, rd_addr;
	logic          armed_n, frozen_n;
	logic [PW:0]   stop_sum, rd_sum;
	logic          accept, wr_en, rd_en;
	logic          valid_s1, frozen_s1, armed_s1, is_read_s1;
	logic [7:0]    wpos_s1;
	logic          rsp_valid_q, adv;
	rsp_t          rsp_q;
	logic [SAMPLE_BITS-1:0] rd_data;

	assign accept    = req_valid && !req_stall;
	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && rsp_valid_q && rsp_stall;
	assign cfg_ready = 1'b1;

	assign wp_inc    = (wp_q == LAST_IDX) ? '0 : wp_q + PW'(1);
	assign stop_sum  = {1'b0, wp_q} + {1'b0, post_q};
	assign stop_calc = (stop_sum >= DEPTH_W) ? PW'(stop_sum - DEPTH_W) : PW'(stop_sum);
	assign rd_sum    = {1'b0, wp_q} + {1'b0, mod_lut[req.read_offset]};
	assign rd_addr   = (rd_sum >= DEPTH_W) ? PW'(rd_sum - DEPTH_W) : PW'(rd_sum);

	always_comb begin
		wp_n     = wp_q;
		stop_n   = stop_q;
		armed_n  = armed_q;
		frozen_n = frozen_q;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		unique case (req.func)
			FUNC_SAMPLE: begin
				if (!frozen_q) begin
					wr_en = accept;
					wp_n  = wp_inc;
					if (armed_q && wp_inc == stop_q) begin
						frozen_n = 1'b1;
					end
				end
			end
			FUNC_TRIGGER: begin
				if (!armed_q) begin
					armed_n = 1'b1;
					stop_n  = stop_calc;
				end
			end
			FUNC_READ: begin
				rd_en = accept;
			end
			FUNC_REARM: begin
				armed_n  = 1'b0;
				frozen_n = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			stop_q   <= '0;
			armed_q  <= 1'b0;
			frozen_q <= 1'b0;
			post_q   <= POST_RESET_MOD;
		end else begin
			if (accept) begin
				wp_q     <= wp_n;
				stop_q   <= stop_n;
				armed_q  <= armed_n;
				frozen_q <= frozen_n;
			end
			if (cfg_valid && cfg_ready) begin
				post_q <= mod_lut[cfg_data];
			end
		end
	end

	trc_store #(
		.DEPTH (BUFFER_DEPTH),
		.WIDTH (SAMPLE_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (SAMPLE_BITS'(req.sample_value)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frozen_s1  <= frozen_n;
			armed_s1   <= armed_n;
			wpos_s1    <= 8'(wp_n);
			is_read_s1 <= (req.func == FUNC_READ);
		end
		if (adv) begin
			rsp_q.read_data      <= is_read_s1 ? 8'(rd_data) : 8'd0;
			rsp_q.is_frozen      <= frozen_s1;
			rsp_q.is_armed       <= armed_s1;
			rsp_q.write_position <= wpos_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_frozen_armed: assert property (@(posedge clk) disable iff (!arst_n)
		frozen_q |-> armed_q)
		else $error("frozen without armed");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, wp_q} < DEPTH_W) && ({1'b0, stop_q} < DEPTH_W))
		else $error("pointer beyond depth");

	a_frozen_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.func == FUNC_SAMPLE && frozen_q) |=> $stable(wp_q))
		else $error("pointer moved while frozen");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && rsp_valid_q))
		else $error("stall with free pipeline");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import trc_pkg::*;

	localparam int DEPTH      = 256;
	localparam int HOLD_LEN   = 300;
	localparam int QUIET_MAX  = 5000;
	localparam int SETTLE_CYC = 4;

	class capture_scoreboard;
		logic [7:0] store [DEPTH];
		bit         written [DEPTH];
		logic [7:0] wp;
		logic [7:0] stop;
		bit         armed;
		bit         frozen;
		logic [7:0] post;
		rsp_t       expected_q[$];
		int         errors;
		int         checked;
		int         accepted;
		int         effective;
		int         freezes;

		function new();
			wp = '0;
			stop = '0;
			armed = 1'b0;
			frozen = 1'b0;
			post = POST_TRIGGER_RESET;
			foreach (written[i]) begin
				written[i] = 1'b0;
				store[i] = '0;
			end
		endfunction

		function bit note_request(req_t r);
			rsp_t exp_rsp;
			bit   took;
			logic [7:0] idx;
			took = 1'b1;
			exp_rsp = '0;
			case (r.func)
				FUNC_SAMPLE: begin
					if (frozen) begin
						took = 1'b0;
					end else begin
						store[wp] = r.sample_value;
						written[wp] = 1'b1;
						wp = wp + 8'd1;
						if (armed && wp == stop) begin
							frozen = 1'b1;
							freezes++;
						end
					end
				end
				FUNC_TRIGGER: begin
					if (armed) begin
						took = 1'b0;
					end else begin
						armed = 1'b1;
						stop = wp + post;
					end
				end
				FUNC_READ: begin
					idx = wp + r.read_offset;
					exp_rsp.read_data = store[idx];
				end
				default: begin
					armed = 1'b0;
					frozen = 1'b0;
				end
			endcase
			exp_rsp.is_frozen = frozen;
			exp_rsp.is_armed = armed;
			exp_rsp.write_position = wp;
			expected_q.push_back(exp_rsp);
			accepted++;
			if (took)
				effective++;
			return took;
		endfunction

		task report_mismatch(string what, int got, int want);
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
			errors++;
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected response transaction", 1, 0);
			end else begin
				want = expected_q.pop_front();
				checked++;
				if (got.read_data !== want.read_data)
					report_mismatch("read_data", int'(got.read_data),
						int'(want.read_data));
				if (got.is_frozen !== want.is_frozen)
					report_mismatch("is_frozen", int'(got.is_frozen),
						int'(want.is_frozen));
				if (got.is_armed !== want.is_armed)
					report_mismatch("is_armed", int'(got.is_armed),
						int'(want.is_armed));
				if (got.write_position !== want.write_position)
					report_mismatch("write_position", int'(got.write_position),
						int'(want.write_position));
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	req_t       req;
	logic       rsp_valid;
	logic       rsp_stall;
	rsp_t       rsp;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	capture_scoreboard sb;
	int    tx_idle_pct;
	int    rx_stall_pct;
	bit    hold_pending;
	int    quiet_cycles;
	string post_list;

	triggered_ring_capture i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_pending = 1'b0;
		quiet_cycles = 0;
		post_list = "";
		sb = new();
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
			end
			rsp_stall <= ($urandom_range(99) < rx_stall_pct);
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("[%0t] no transaction for %0d cycles", $realtime, QUIET_MAX);
			$display("Verification failed");
			$finish;
		end
	end

	function automatic req_t make_req(func_t f);
		req_t r;
		r.func = f;
		r.sample_value = 8'($urandom_range(255));
		r.read_offset = 8'($urandom_range(255));
		return r;
	endfunction

	// steer the offset onto an entry that has been written
	function automatic req_t make_read(int off);
		req_t       r;
		logic [7:0] idx;
		r = make_req(FUNC_READ);
		if (off >= 0)
			r.read_offset = 8'(off);
		for (int i = 0; i < DEPTH; i++) begin
			idx = sb.wp + r.read_offset;
			if (sb.written[idx])
				return r;
			r.read_offset = r.read_offset + 8'd1;
		end
		return make_req(FUNC_SAMPLE);
	endfunction

	task automatic send_item(input req_t r);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		void'(sb.note_request(r));
		if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	task automatic send_sample(logic [7:0] value);
		req_t r;
		r = make_req(FUNC_SAMPLE);
		r.sample_value = value;
		send_item(r);
	endtask

	task automatic drain_and_settle();
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_post(logic [7:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.post = value;
		post_list = {post_list, $sformatf(" %0d", value)};
	endtask

	task automatic run_directed();
		write_post(8'd3);
		send_sample(8'h00);
		send_sample(8'hFF);
		send_sample(8'hA5);
		send_sample(8'h5A);
		send_item(make_read(255));
		send_item(make_read(252));
		send_item(make_req(FUNC_TRIGGER));
		send_item(make_req(FUNC_TRIGGER));
		send_sample(8'h01);
		send_sample(8'h80);
		send_sample(8'h7F);
		send_sample(8'hFE);
		send_item(make_read(0));
		send_item(make_read(255));
		send_item(make_req(FUNC_REARM));
		send_item(make_req(FUNC_REARM));
		send_item(make_req(FUNC_TRIGGER));
		send_sample(8'hC3);
		send_item(make_read(254));
		send_item(make_req(FUNC_REARM));
		req_valid <= 1'b0;
	endtask

	task automatic run_noise(int count);
		func_t f;
		repeat (count) begin
			f = func_t'($urandom_range(3));
			if (f == FUNC_READ)
				send_item(make_read(-1));
			else
				send_item(make_req(f));
		end
	endtask

	task automatic run_episode();
		int pre_len;
		int post_len;
		int pick;
		send_item(make_req(FUNC_REARM));
		pre_len = $urandom_range(0, 30);
		repeat (pre_len) send_item(make_req(FUNC_SAMPLE));
		send_item(make_req(FUNC_TRIGGER));
		post_len = ((sb.post == 0) ? DEPTH : sb.post) + $urandom_range(0, 4);
		repeat (post_len) begin
			pick = $urandom_range(99);
			if (pick < 8)
				send_item(make_read(-1));
			else if (pick < 11)
				send_item(make_req(FUNC_TRIGGER));
			else if (pick < 12)
				send_item(make_req(FUNC_REARM));
			else
				send_item(make_req(FUNC_SAMPLE));
		end
		repeat ($urandom_range(3, 12)) send_item(make_read(-1));
		repeat ($urandom_range(0, 3)) send_item(make_req(FUNC_SAMPLE));
		if ($urandom_range(3) == 0)
			run_noise($urandom_range(4, 12));
	endtask

	task automatic run_phase(logic [7:0] post_val, int tx_pct, int rx_pct, int target, bit hold);
		int eff_start;
		drain_and_settle();
		write_post(post_val);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		if (hold)
			hold_pending = 1'b1;
		eff_start = sb.effective;
		while (sb.effective - eff_start < target) run_episode();
		req_valid <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_phase(POST_TRIGGER_RESET, 0, 0, 250, 1'b0);
		run_phase(8'd0, 47, 0, 200, 1'b0);
		run_phase(8'd255, 0, 47, 200, 1'b1);
		run_phase(8'($urandom_range(1, 40)), 37, 37, 200, 1'b0);
		run_phase(8'd1, 0, 0, 150, 1'b1);
		drain_and_settle();
		repeat (10) @(posedge clk);
		$display("Covered %0d request transactions (%0d ignored by the block), %0d captures frozen",
			sb.accepted, sb.accepted - sb.effective, sb.freezes);
		$display("Checked %0d responses over post-trigger settings:%s", sb.checked, post_list);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
